// ===== rtl/hlsrgb_pkg.sv =====
// Shared types and constants for the HSL to RGB converter.
// Used by every module of the block; depends on nothing else.
package hlsrgb_pkg;

  localparam int FRAC_BITS = 12;
  localparam int LVL_W     = FRAC_BITS + 1;
  localparam int HUE_W     = 13;
  localparam int T_W       = 11;
  localparam int BYTE_W    = 8;

  localparam logic [LVL_W-1:0] LVL_ONE  = LVL_W'(1 << FRAC_BITS);
  localparam logic [LVL_W-1:0] LVL_HALF = LVL_W'(1 << (FRAC_BITS - 1));

  // Hue in sixteenths of a degree.
  localparam logic [HUE_W-1:0] HUE_60   = HUE_W'(960);
  localparam logic [HUE_W-1:0] HUE_120  = HUE_W'(1920);
  localparam logic [HUE_W-1:0] HUE_180  = HUE_W'(2880);
  localparam logic [HUE_W-1:0] HUE_240  = HUE_W'(3840);
  localparam logic [HUE_W-1:0] HUE_FULL = HUE_W'(5760);

  // Division by 960 is done as a shift by 6 followed by a reciprocal
  // multiply for division by 15, exact for every 16-bit quotient input.
  localparam int PROD_W     = LVL_W + T_W;
  localparam int PRE_SHIFT  = 6;
  localparam int QIN_W      = 16;
  localparam int RECIP_W    = 16;
  localparam int RECIP_SH   = 19;
  localparam logic [RECIP_W-1:0] RECIP_15 = RECIP_W'(34953);

  localparam logic [BYTE_W-1:0] BYTE_MAX = '1;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [LVL_W-1:0] lightness;
    logic [LVL_W-1:0] saturation;
  } pixel_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
  } pixel_out_t;

  // Region of one channel's ramp: flat at the high level, or the low
  // level plus span * t / 960.
  typedef struct packed {
    logic           hi;
    logic [T_W-1:0] t;
  } hue_sel_t;

  typedef struct packed {
    logic [LVL_W-1:0] base;
    logic [T_W-1:0]   t;
  } chan_t;

  typedef struct packed {
    logic [LVL_W-1:0] span;
    chan_t            red;
    chan_t            green;
    chan_t            blue;
  } lvl_t;

endpackage

// ===== rtl/hlsrgb_levels.sv =====
// First two pipeline stages: input clamping, hue decode per channel,
// lightness times saturation, and the m1/m2 levels. Uses hlsrgb_pkg.
module hlsrgb_levels import hlsrgb_pkg::*; (
  input  logic      clk,
  input  logic      en1,
  input  logic      en2,
  input  pixel_in_t hls,
  output lvl_t      lvl
);

  function automatic hue_sel_t decode(input logic [HUE_W-1:0] hc);
    hue_sel_t r;
    r.hi = 1'b0;
    r.t  = '0;
    if (hc < HUE_60) begin
      r.t = hc[T_W-1:0];
    end else if (hc < HUE_180) begin
      r.hi = 1'b1;
    end else if (hc < HUE_240) begin
      r.t = T_W'(HUE_240 - hc);
    end
    return r;
  endfunction

  logic [HUE_W-1:0]   hue_w;
  logic [HUE_W-1:0]   hue_r;
  logic [HUE_W-1:0]   hue_b;
  logic [LVL_W-1:0]   l_c;
  logic [LVL_W-1:0]   s_c;
  logic [2*LVL_W-1:0] ls_full;

  logic [LVL_W-1:0] l1;
  logic [LVL_W-1:0] s1;
  logic [LVL_W-1:0] p1;
  hue_sel_t         sel_r1;
  hue_sel_t         sel_g1;
  hue_sel_t         sel_b1;

  logic [LVL_W:0]          m2_w;
  logic signed [LVL_W+1:0] m1_s;
  logic [LVL_W-1:0]        m1;
  logic [LVL_W-1:0]        m2;

  always_comb begin
    hue_w = (hls.hue >= HUE_FULL) ? hls.hue - HUE_FULL : hls.hue;
    // A red hue of exactly 360 degrees is kept as is and lands on the low level.
    hue_r = (hue_w <= HUE_240) ? hue_w + HUE_120 : hue_w - HUE_240;
    hue_b = (hue_w < HUE_120) ? hue_w + HUE_240 : hue_w - HUE_120;
    l_c = (hls.lightness > LVL_ONE) ? LVL_ONE : hls.lightness;
    s_c = (hls.saturation > LVL_ONE) ? LVL_ONE : hls.saturation;
    ls_full = l_c * s_c;
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      l1     <= l_c;
      s1     <= s_c;
      p1     <= ls_full[FRAC_BITS +: LVL_W];
      sel_r1 <= decode(hue_r);
      sel_g1 <= decode(hue_w);
      sel_b1 <= decode(hue_b);
    end
  end

  // For l <= 1/2, l*(1+s) truncated equals l plus the truncated product.
  always_comb begin
    if (l1 <= LVL_HALF) begin
      m2_w = {1'b0, l1} + {1'b0, p1};
    end else begin
      m2_w = {1'b0, l1} + {1'b0, s1} - {1'b0, p1};
    end
    m1_s = signed'({1'b0, l1, 1'b0}) - signed'({1'b0, m2_w});
    m1   = m1_s[LVL_W+1] ? '0 : m1_s[LVL_W-1:0];
    m2   = m2_w[LVL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      lvl.span       <= m2 - m1;
      lvl.red.base   <= sel_r1.hi ? m2 : m1;
      lvl.red.t      <= sel_r1.t;
      lvl.green.base <= sel_g1.hi ? m2 : m1;
      lvl.green.t    <= sel_g1.t;
      lvl.blue.base  <= sel_b1.hi ? m2 : m1;
      lvl.blue.t     <= sel_b1.t;
    end
  end

endmodule

// ===== rtl/hlsrgb_ramp.sv =====
// Pipeline stages three to five for one color channel: ramp product,
// division by 960, and scaling of the level to a byte. Uses hlsrgb_pkg.
module hlsrgb_ramp import hlsrgb_pkg::*; (
  input  logic              clk,
  input  logic              en3,
  input  logic              en4,
  input  logic              en5,
  input  logic [LVL_W-1:0]  span,
  input  chan_t             chan,
  output logic [BYTE_W-1:0] level_byte
);

  logic [PROD_W-1:0]          prod_full;
  logic [PROD_W-1:0]          prod3;
  logic [LVL_W-1:0]           base3;
  logic [QIN_W-1:0]           quo_in;
  logic [QIN_W+RECIP_W-1:0]   recip_full;
  logic [LVL_W-1:0]           quo4;
  logic [LVL_W-1:0]           base4;
  logic [LVL_W:0]             level;
  logic [LVL_W+BYTE_W:0]      scaled;
  logic [LVL_W+BYTE_W-FRAC_BITS:0] scaled_hi;

  assign prod_full = span * chan.t;

  always_ff @(posedge clk) begin
    if (en3) begin
      prod3 <= prod_full;
      base3 <= chan.base;
    end
  end

  assign quo_in     = prod3[PRE_SHIFT +: QIN_W];
  assign recip_full = quo_in * RECIP_15;

  always_ff @(posedge clk) begin
    if (en4) begin
      quo4  <= recip_full[RECIP_SH +: LVL_W];
      base4 <= base3;
    end
  end

  // 255 * level is formed as level * 256 - level.
  always_comb begin
    level     = {1'b0, base4} + {1'b0, quo4};
    scaled    = {level, {BYTE_W{1'b0}}} - {{BYTE_W{1'b0}}, level};
    scaled_hi = scaled[LVL_W+BYTE_W:FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      level_byte <= (scaled_hi > {{(LVL_W+1-FRAC_BITS){1'b0}}, BYTE_MAX}) ?
                    BYTE_MAX : scaled_hi[BYTE_W-1:0];
    end
  end

endmodule

// ===== rtl/hls_to_rgb_converter.sv =====
// HSL to RGB converter. One item (hue, lightness, saturation) enters per clock
// when the output side does not stall, and its red, green and blue bytes leave
// in order. The five register stages each hold their own valid bit:
// clamp and multiply, m1/m2 levels, ramp product, reciprocal divide by 960, and
// byte scaling into the output register. A stalled output fills empty stages
// first, so the input keeps taking items until all five stages are occupied.
module hls_to_rgb_converter import hlsrgb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       hls_valid,
  output logic       hls_stall,
  input  pixel_in_t  hls,
  output logic       rgb_valid,
  input  logic       rgb_stall,
  output pixel_out_t rgb
);

  logic [5:1] v;
  logic [5:1] en;
  lvl_t       lvl;

  always_comb begin
    en[5] = !v[5] || !rgb_stall;
    en[4] = !v[4] || en[5];
    en[3] = !v[3] || en[4];
    en[2] = !v[2] || en[3];
    en[1] = !v[1] || en[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) begin
        v[1] <= hls_valid;
      end
      if (en[2]) begin
        v[2] <= v[1];
      end
      if (en[3]) begin
        v[3] <= v[2];
      end
      if (en[4]) begin
        v[4] <= v[3];
      end
      if (en[5]) begin
        v[5] <= v[4];
      end
    end
  end

  assign hls_stall = !en[1];
  assign rgb_valid = v[5];

  hlsrgb_levels u_levels (
    .clk (clk),
    .en1 (en[1]),
    .en2 (en[2]),
    .hls (hls),
    .lvl (lvl)
  );

  hlsrgb_ramp u_red (
    .clk        (clk),
    .en3        (en[3]),
    .en4        (en[4]),
    .en5        (en[5]),
    .span       (lvl.span),
    .chan       (lvl.red),
    .level_byte (rgb.red)
  );

  hlsrgb_ramp u_green (
    .clk        (clk),
    .en3        (en[3]),
    .en4        (en[4]),
    .en5        (en[5]),
    .span       (lvl.span),
    .chan       (lvl.green),
    .level_byte (rgb.green)
  );

  hlsrgb_ramp u_blue (
    .clk        (clk),
    .en3        (en[3]),
    .en4        (en[4]),
    .en5        (en[5]),
    .span       (lvl.span),
    .chan       (lvl.blue),
    .level_byte (rgb.blue)
  );

  // With the output register empty the whole pipeline can move.
  a_empty_out_no_stall: assert property (@(posedge clk) disable iff (rst)
    !rgb_valid |-> !hls_stall)
    else $error("input stalled while the output register is empty");

  // An accepted item reaches the output when the output does not stall meanwhile.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (hls_valid && !hls_stall) ##1 !rgb_stall ##1 !rgb_stall ##1 !rgb_stall
      ##1 !rgb_stall |=> rgb_valid)
    else $error("accepted item did not reach the output in time");

  // Only the stalled output can hold the input back.
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    hls_stall |-> (rgb_valid && rgb_stall))
    else $error("input stalled without a stalled output");

endmodule

// ===== tb/sv/hls_to_rgb_converter_tb.sv =====
// Self-checking testbench for hls_to_rgb_converter: directed table plus random
// colors, with random idling on both channels and long output hold-offs.
// Depends on hlsrgb_pkg and the hls_to_rgb_converter RTL.
`timescale 1ns / 100ps

module hls_to_rgb_converter_tb;
  import hlsrgb_pkg::*;

  localparam int RESET_CYCLES = 7;
  localparam int RANDOM_ITEMS = 500;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES  = 80;

  typedef struct {
    pixel_in_t  px;
    bit         typed;
    pixel_out_t rgb_want;
  } directed_row_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       hls_valid = 1'b0;
  logic       hls_stall;
  pixel_in_t  hls = '0;
  logic       rgb_valid;
  logic       rgb_stall = 1'b0;
  pixel_out_t rgb;

  pixel_out_t    expected_rgb_q[$];
  directed_row_t directed_rows[$];
  int            mismatch_count = 0;
  int            sent_count = 0;
  bit            sender_burst = 1'b0;

  hls_to_rgb_converter DUT (
    .clk       (clk),
    .rst       (rst),
    .hls_valid (hls_valid),
    .hls_stall (hls_stall),
    .hls       (hls),
    .rgb_valid (rgb_valid),
    .rgb_stall (rgb_stall),
    .rgb       (rgb)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Level in Q(FRAC_BITS) to a byte: floor(255 * v / one), clamped.
  function automatic logic [BYTE_W-1:0] level_to_byte(int v);
    int x;
    if (v <= 0) return '0;
    x = (255 * v) >>> FRAC_BITS;
    if (x >= 255) return BYTE_MAX;
    return BYTE_W'(x);
  endfunction

  // One channel's piecewise ramp. A wrapped hue of exactly 360 degrees
  // falls through to the low level.
  function automatic int hue_ramp_level(int lo, int hi, int hue);
    if (hue > int'(HUE_FULL)) hue -= int'(HUE_FULL);
    else if (hue < 0) hue += int'(HUE_FULL);
    if (hue < int'(HUE_60)) return lo + (hi - lo) * hue / int'(HUE_60);
    if (hue < int'(HUE_180)) return hi;
    if (hue < int'(HUE_240)) return lo + (hi - lo) * (int'(HUE_240) - hue) / int'(HUE_60);
    return lo;
  endfunction

  function automatic pixel_out_t predict_rgb(pixel_in_t px);
    int one, hue, lum, sat, hi_lvl, lo_lvl;
    pixel_out_t res;
    one = 1 << FRAC_BITS;
    hue = int'(px.hue);
    lum = (int'(px.lightness) > one) ? one : int'(px.lightness);
    sat = (int'(px.saturation) > one) ? one : int'(px.saturation);
    if (hue >= int'(HUE_FULL)) hue -= int'(HUE_FULL);
    if (sat == 0) begin
      res.red   = level_to_byte(lum);
      res.green = res.red;
      res.blue  = res.red;
      return res;
    end
    if (lum <= (one >> 1)) hi_lvl = (lum * (one + sat)) >>> FRAC_BITS;
    else hi_lvl = lum + sat - ((lum * sat) >>> FRAC_BITS);
    lo_lvl = 2 * lum - hi_lvl;
    if (lo_lvl < 0) lo_lvl = 0;
    res.red   = level_to_byte(hue_ramp_level(lo_lvl, hi_lvl, hue + int'(HUE_120)));
    res.green = level_to_byte(hue_ramp_level(lo_lvl, hi_lvl, hue));
    res.blue  = level_to_byte(hue_ramp_level(lo_lvl, hi_lvl, hue - int'(HUE_120)));
    return res;
  endfunction

  function automatic logic [LVL_W-1:0] random_level();
    case ($urandom_range(0, 9))
      0: return LVL_W'($urandom_range(0, (1 << LVL_W) - 1));
      1: return ($urandom_range(0, 1) != 0) ? LVL_ONE : '0;
      2: return LVL_W'(int'(LVL_HALF) - 1 + int'($urandom_range(0, 2)));
      default: return LVL_W'($urandom_range(0, 1 << FRAC_BITS));
    endcase
  endfunction

  // Mostly legal hues, some right at the 60-degree region edges, and some
  // over 360 degrees so that every hue bit toggles.
  function automatic logic [HUE_W-1:0] random_hue();
    int h;
    case ($urandom_range(0, 9))
      0: return HUE_W'($urandom_range(0, (1 << HUE_W) - 1));
      1: begin
        h = int'($urandom_range(0, 6)) * int'(HUE_60) + int'($urandom_range(0, 2)) - 1;
        return HUE_W'((h < 0) ? 0 : h);
      end
      default: return HUE_W'($urandom_range(0, int'(HUE_FULL) - 1));
    endcase
  endfunction

  task automatic add_row(int h, int l, int s, bit typed, int r, int g, int b);
    directed_row_t row;
    row.px.hue         = HUE_W'(h);
    row.px.lightness   = LVL_W'(l);
    row.px.saturation  = LVL_W'(s);
    row.typed          = typed;
    row.rgb_want.red   = BYTE_W'(r);
    row.rgb_want.green = BYTE_W'(g);
    row.rgb_want.blue  = BYTE_W'(b);
    directed_rows.push_back(row);
  endtask

  // Offers one item after a random gap and returns at the edge that takes it.
  // Valid is only lowered when a gap follows, so back-to-back items keep it high.
  task automatic send_pixel(pixel_in_t px, bit typed, pixel_out_t rgb_want);
    int gap;
    if (sent_count % 40 == 0) sender_burst = ($urandom_range(0, 3) == 0);
    gap = sender_burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      hls_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    hls       <= px;
    hls_valid <= 1'b1;
    @(posedge clk);
    while (hls_stall) @(posedge clk);
    expected_rgb_q.push_back(typed ? rgb_want : predict_rgb(px));
    sent_count++;
  endtask

  // Output side: a random stall before each item, zero-stall stretches, and
  // two long hold-offs that let the pipeline fill and back up to the input.
  initial begin
    int hold;
    int taken;
    bit rx_burst;
    taken = 0;
    rx_burst = 1'b0;
    forever begin
      if (taken % 50 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      if (taken == 120 || taken == 350) hold = HOLD_CYCLES;
      else hold = rx_burst ? 0 : $urandom_range(0, 6);
      if (hold > 0) begin
        rgb_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      rgb_stall <= 1'b0;
      @(posedge clk);
      while (!(rgb_valid && !rst)) @(posedge clk);
      taken++;
    end
  end

  always @(posedge clk) begin
    pixel_out_t want;
    if (!rst && rgb_valid && !rgb_stall) begin
      if (expected_rgb_q.size() == 0) begin
        $display("%0t: unexpected rgb item, actual %h", $time, rgb);
        mismatch_count++;
      end else begin
        want = expected_rgb_q.pop_front();
        if (rgb.red !== want.red) begin
          $display("%0t: red expected %0d actual %0d", $time, want.red, rgb.red);
          mismatch_count++;
        end
        if (rgb.green !== want.green) begin
          $display("%0t: green expected %0d actual %0d", $time, want.green, rgb.green);
          mismatch_count++;
        end
        if (rgb.blue !== want.blue) begin
          $display("%0t: blue expected %0d actual %0d", $time, want.blue, rgb.blue);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("hls_to_rgb_converter_tb: errors");
    $finish;
  end

  initial begin
    pixel_in_t px;
    //      hue   light sat   typed red  green blue
    add_row(0,    0,    0,    1,    0,   0,    0);
    add_row(0,    4096, 0,    1,    255, 255,  255);
    add_row(5759, 2048, 0,    1,    127, 127,  127);
    add_row(0,    8191, 0,    1,    255, 255,  255);   // lightness over 1.0
    add_row(0,    2048, 4096, 1,    255, 0,    0);
    add_row(1920, 2048, 4096, 1,    0,   255,  0);
    add_row(3840, 2048, 4096, 1,    0,   0,    255);   // red hue wraps to exactly 360
    add_row(5760, 2048, 4096, 1,    255, 0,    0);     // hue of 360 reduces to 0
    add_row(0,    2048, 8191, 1,    255, 0,    0);     // saturation over 1.0
    add_row(500,  4096, 4096, 1,    255, 255,  255);
    add_row(5759, 2048, 4096, 0,    0,   0,    0);
    add_row(959,  2048, 4096, 0,    0,   0,    0);
    add_row(960,  2048, 4096, 0,    0,   0,    0);
    add_row(2879, 2048, 4096, 0,    0,   0,    0);
    add_row(2880, 2048, 4096, 0,    0,   0,    0);
    add_row(1,    2048, 4096, 0,    0,   0,    0);
    add_row(8191, 1000, 3000, 0,    0,   0,    0);
    add_row(7679, 3000, 1500, 0,    0,   0,    0);
    add_row(1000, 2049, 2000, 0,    0,   0,    0);
    add_row(4000, 1,    1,    0,    0,   0,    0);
    add_row(2000, 4095, 4095, 0,    0,   0,    0);
    add_row(4800, 2047, 8191, 0,    0,   0,    0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_pixel(directed_rows[i].px, directed_rows[i].typed, directed_rows[i].rgb_want);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      px.hue        = random_hue();
      px.lightness  = random_level();
      px.saturation = ($urandom_range(0, 9) == 0) ? '0 : random_level();
      send_pixel(px, 1'b0, '0);
    end
    hls_valid <= 1'b0;

    while (expected_rgb_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("hls_to_rgb_converter_tb: clean");
    end else begin
      $display("hls_to_rgb_converter_tb: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/hlsrgb_pkg.sv
rtl/hlsrgb_levels.sv
rtl/hlsrgb_ramp.sv
rtl/hls_to_rgb_converter.sv
tb/sv/hls_to_rgb_converter_tb.sv
